// ----- hw/rtl/bcc_pkg.sv -----
// Shared types, constants and helpers for the bracket class compiler.
package bcc_pkg;

    localparam int SET_SIZE     = 256;
    localparam int WORD_W       = 64;
    localparam int NWORDS       = SET_SIZE / WORD_W;
    localparam int WIDX_W       = $clog2(NWORDS);
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CTL_MASK  = 8'h1F;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_OPEN,
        PH_ELEM,
        PH_ESC_E,
        PH_OCT_E,
        PH_HEX_E,
        PH_CTL_E,
        PH_AFTER,
        PH_RANGE,
        PH_ESC_R,
        PH_OCT_R,
        PH_HEX_R,
        PH_CTL_R
    } phase_t;

    typedef enum logic [1:0] {
        ACT_DONE,
        ACT_AGAIN,
        ACT_ERR,
        ACT_EMIT
    } act_t;

    // One finished class (or one error) handed from the parser to the emitter.
    typedef struct packed {
        logic                err;
        logic                inv;
        logic [SET_SIZE-1:0] bits;
    } bcc_job_t;

    // Queue status seen by the parser and the emitter.
    typedef struct packed {
        logic full;
        logic valid;
    } bcc_qstat_t;

    // Inclusive lo..hi membership mask.
    function automatic logic [SET_SIZE-1:0] span_mask(logic [7:0] lo, logic [7:0] hi);
        logic [SET_SIZE-1:0] ones;
        ones = '1;
        return (ones << lo) & (ones >> (8'd255 - hi));
    endfunction

endpackage

// ----- hw/rtl/bcc_front.sv -----
// Parser front end: accepts text bytes, tracks the class syntax and builds the bitmap.
module bcc_front
    import bcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    input  logic       text_valid,
    output logic       text_ready,
    input  bcc_qstat_t qstat,
    output logic       push,
    output bcc_job_t   job
);

    typedef struct packed {
        phase_t      phase;
        logic [8:0]  esc_val;
        logic [1:0]  esc_cnt;
        logic [7:0]  rstart;
        logic        inv;
        logic        clear;
    } pstate_t;

    typedef struct packed {
        pstate_t     st;
        act_t        act;
        logic        span;
        logic [7:0]  lo;
        logic [7:0]  hi;
    } pass_out_t;

    // One pass of the parser over the current byte. A span request replaces
    // the bitmap update so the caller can merge all spans of one byte.
    function automatic pass_out_t parse_pass(pstate_t s, logic [7:0] b);
        pass_out_t  r;
        logic       rng;
        logic       dlv;
        logic [7:0] dv;
        logic [8:0] v;
        logic [1:0] c;
        logic       hv;
        logic [3:0] hd;
        r      = '0;
        r.st   = s;
        r.act  = ACT_DONE;
        rng    = 1'b0;
        dlv    = 1'b0;
        dv     = '0;
        v      = s.esc_val;
        c      = s.esc_cnt;
        hv     = 1'b0;
        hd     = '0;
        case (b) inside
            ["0":"9"]: begin hv = 1'b1; hd = b[3:0]; end
            ["a":"f"], ["A":"F"]: begin hv = 1'b1; hd = b[3:0] + 4'd9; end
            default: ;
        endcase
        unique case (s.phase)
            PH_IDLE: begin
                if (b != CH_OPEN) begin
                    r.act = ACT_ERR;
                end else begin
                    r.st.clear = 1'b1;
                    r.st.inv   = 1'b0;
                    r.st.phase = PH_OPEN;
                end
            end
            PH_OPEN: begin
                r.st.phase = PH_ELEM;
                if (b == CH_CARET)
                begin
                    r.st.inv = 1'b1;
                end else begin
                    r.act = ACT_AGAIN;
                end
            end
            PH_ELEM: begin
                if (b == CH_CLOSE) begin
                    r.act = ACT_EMIT;
                end else if (b == CH_BSLASH) begin
                    r.st.phase = PH_ESC_E;
                end else begin
                    dlv = 1'b1;
                    dv  = b;
                end
            end
            PH_AFTER: begin
                if (b == CH_DASH) begin
                    r.st.phase = PH_RANGE;
                end else begin
                    r.st.phase = PH_ELEM;
                    r.act      = ACT_AGAIN;
                end
            end
            PH_RANGE: begin
                if (b == CH_BSLASH) begin
                    r.st.phase = PH_ESC_R;
                end else begin
                    dlv = 1'b1;
                    dv  = b;
                    rng = 1'b1;
                end
            end
            PH_ESC_E, PH_ESC_R: begin
                rng = (s.phase == PH_ESC_R);
                unique case (b) inside
                    "n": begin dlv = 1'b1; dv = 8'h0A; end
                    "r": begin dlv = 1'b1; dv = 8'h0D; end
                    "t": begin dlv = 1'b1; dv = 8'h09; end
                    "f": begin dlv = 1'b1; dv = 8'h0C; end
                    "b": begin dlv = 1'b1; dv = 8'h08; end
                    "a": begin dlv = 1'b1; dv = 8'h07; end
                    "v": begin dlv = 1'b1; dv = 8'h0B; end
                    "e": begin dlv = 1'b1; dv = 8'h1B; end
                    ["0":"7"]: begin
                        v          = {6'd0, b[2:0]};
                        c          = 2'd1;
                        r.st.phase = rng ? PH_OCT_R : PH_OCT_E;
                    end
                    "x", "X": begin
                        v          = '0;
                        c          = 2'd0;
                        r.st.phase = rng ? PH_HEX_R : PH_HEX_E;
                    end
                    "c", "C": begin
                        r.st.phase = rng ? PH_CTL_R : PH_CTL_E;
                    end
                    default: begin
                        dlv = 1'b1;
                        dv  = b;
                    end
                endcase
            end
            PH_OCT_E, PH_OCT_R: begin
                rng = (s.phase == PH_OCT_R);
                if (b >= "0" && b <= "7") begin
                    v = {v[5:0], b[2:0]};
                    c = c + 2'd1;
                    if (c == 2'd3) begin
                        if (v[8]) begin
                            r.act = ACT_ERR;
                        end else begin
                            dlv = 1'b1;
                            dv  = v[7:0];
                        end
                    end
                end else begin
                    dlv   = 1'b1;
                    dv    = v[7:0];
                    r.act = ACT_AGAIN;
                end
            end
            PH_HEX_E, PH_HEX_R: begin
                rng = (s.phase == PH_HEX_R);
                if (hv) begin
                    v = {v[4:0], hd};
                    c = c + 2'd1;
                    if (c == 2'd2) begin
                        dlv = 1'b1;
                        dv  = v[7:0];
                    end
                end else if (c == 2'd0) begin
                    r.act = ACT_ERR;
                end else begin
                    dlv   = 1'b1;
                    dv    = v[7:0];
                    r.act = ACT_AGAIN;
                end
            end
            PH_CTL_E, PH_CTL_R: begin
                rng = (s.phase == PH_CTL_R);
                dlv = 1'b1;
                dv  = b & CTL_MASK;
            end
            default: r.act = ACT_ERR;
        endcase
        r.st.esc_val = v;
        r.st.esc_cnt = c;
        if (dlv) begin
            r.span = 1'b1;
            if (rng) begin
                r.lo       = (s.rstart <= dv) ? s.rstart : dv;
                r.hi       = (s.rstart <= dv) ? dv : s.rstart;
                r.st.phase = PH_ELEM;
            end else begin
                r.lo        = dv;
                r.hi        = dv;
                r.st.rstart = dv;
                r.st.phase  = PH_AFTER;
            end
        end
        return r;
    endfunction

    phase_t              phase_reg, phase_next;
    logic [8:0]          esc_val_reg, esc_val_next;
    logic [1:0]          esc_cnt_reg, esc_cnt_next;
    logic [7:0]          rstart_reg, rstart_next;
    logic                inv_reg, inv_next;
    logic [SET_SIZE-1:0] bitmap_reg, bitmap_next;

    logic accept;

    assign text_ready = !qstat.full;
    assign accept     = text_valid && text_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            esc_val_reg <= '0;
            esc_cnt_reg <= '0;
            rstart_reg  <= '0;
            inv_reg     <= 1'b0;
            bitmap_reg  <= '0;
        end else begin
            phase_reg   <= phase_next;
            esc_val_reg <= esc_val_next;
            esc_cnt_reg <= esc_cnt_next;
            rstart_reg  <= rstart_next;
            inv_reg     <= inv_next;
            bitmap_reg  <= bitmap_next;
        end
    end

    always_comb begin
        pstate_t             st;
        pass_out_t           po;
        act_t                act;
        logic                fin;
        logic                s0_v;
        logic                s1_v;
        logic [7:0]          s0_lo, s0_hi, s1_lo, s1_hi;
        logic [SET_SIZE-1:0] merged;

        st         = '0;
        st.phase   = phase_reg;
        st.esc_val = esc_val_reg;
        st.esc_cnt = esc_cnt_reg;
        st.rstart  = rstart_reg;
        st.inv     = inv_reg;
        act        = ACT_AGAIN;
        fin        = 1'b0;
        s0_v       = 1'b0;
        s1_v       = 1'b0;
        s0_lo      = '0;
        s0_hi      = '0;
        s1_lo      = '0;
        s1_hi      = '0;
        po         = '0;

        // A byte that ends a numeric escape or follows an element may be
        // re-examined in the next phase; at most a few passes are needed.
        for (int p = 0; p < 4; p++) begin
            if (!fin) begin
                po  = parse_pass(st, char_code);
                st  = po.st;
                act = po.act;
                if (po.span) begin
                    if (!s0_v) begin
                        s0_v  = 1'b1;
                        s0_lo = po.lo;
                        s0_hi = po.hi;
                    end else begin
                        s1_v  = 1'b1;
                        s1_lo = po.lo;
                        s1_hi = po.hi;
                    end
                end
                if (po.act != ACT_AGAIN) begin
                    fin = 1'b1;
                end
            end
        end
        if (act == ACT_AGAIN || end_of_text) begin
            act = ACT_ERR;
        end

        merged = bitmap_reg
               | (s0_v ? span_mask(s0_lo, s0_hi) : '0)
               | (s1_v ? span_mask(s1_lo, s1_hi) : '0);
        if (st.clear) begin
            merged = '0;
        end

        job.err  = (act == ACT_ERR);
        job.inv  = (act == ACT_EMIT) ? st.inv : 1'b0;
        job.bits = (act == ACT_EMIT) ? merged : '0;
        push     = accept && (act == ACT_ERR || act == ACT_EMIT);

        phase_next   = phase_reg;
        esc_val_next = esc_val_reg;
        esc_cnt_next = esc_cnt_reg;
        rstart_next  = rstart_reg;
        inv_next     = inv_reg;
        bitmap_next  = bitmap_reg;
        if (accept) begin
            if (act == ACT_ERR || act == ACT_EMIT) begin
                phase_next   = PH_IDLE;
                esc_val_next = '0;
                esc_cnt_next = '0;
                rstart_next  = '0;
                inv_next     = 1'b0;
                bitmap_next  = '0;
            end else begin
                phase_next   = st.phase;
                esc_val_next = st.esc_val;
                esc_cnt_next = st.esc_cnt;
                rstart_next  = st.rstart;
                inv_next     = st.inv;
                bitmap_next  = merged;
            end
        end
    end

endmodule

// ----- hw/rtl/bcc_queue.sv -----
// Short job queue between the parser and the emitter.
module bcc_queue
    import bcc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bcc_job_t   push_job,
    input  logic       pop,
    output bcc_job_t   head,
    output bcc_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    bcc_job_t          entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == FULL_CNT);
    assign qstat.valid = (count_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- hw/rtl/bcc_back.sv -----
// Emitter back end: turns queued jobs into result beats through an output register.
module bcc_back
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bcc_job_t          head,
    input  bcc_qstat_t        qstat,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [WIDX_W-1:0] word_index,
    output logic [WORD_W-1:0] set_bits,
    output logic              inverted,
    output logic              parse_error,
    output logic              last
);

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NWORDS - 1);

    logic              valid_reg, valid_next;
    logic [WIDX_W-1:0] cnt_reg, cnt_next;
    logic [WIDX_W-1:0] widx_reg;
    logic [WORD_W-1:0] bits_reg;
    logic              inv_reg;
    logic              err_reg;
    logic              last_reg;

    logic              load;
    logic              beat_last;
    logic [WORD_W-1:0] word_sel;

    assign load      = qstat.valid && (!valid_reg || result_ready);
    assign beat_last = head.err || (cnt_reg == LAST_WORD);
    assign word_sel  = head.bits[cnt_reg * WORD_W +: WORD_W] ^ {WORD_W{head.inv}};
    assign pop       = load && beat_last;

    always_comb begin
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        if (load) begin
            valid_next = 1'b1;
            cnt_next   = beat_last ? '0 : cnt_reg + 1'b1;
        end else if (result_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            widx_reg <= head.err ? '0 : cnt_reg;
            bits_reg <= head.err ? '0 : word_sel;
            inv_reg  <= head.err ? 1'b0 : head.inv;
            err_reg  <= head.err;
            last_reg <= beat_last;
        end
    end

    assign result_valid = valid_reg;
    assign word_index   = widx_reg;
    assign set_bits     = bits_reg;
    assign inverted     = inv_reg;
    assign parse_error  = err_reg;
    assign last         = last_reg;

endmodule

// ----- hw/rtl/bracket_charset_compiler_unit.sv -----
// Top level of the bracket class compiler: parser, job queue and emitter.
//
// Text channel: text_valid/text_ready carry one byte (char_code) or an
// end-of-text mark (end_of_text) per beat. The parser takes one beat every
// cycle while the job queue has room; escapes, ranges and the byte that ends
// a numeric escape are all resolved combinationally as the beat is accepted.
// Result channel: result_valid/result_ready carry one 64-bit word of the class
// bitmap per beat. A closed class gives four beats, word_index 0 to 3, with
// last on word 3 and the bits already inverted if the class began with a
// caret. A syntax fault (bad opening, end of text, bad escape) gives a single
// beat with parse_error and last set and zero bits, and the parser returns
// to idle.
// The first beat of a class is offered once the output register has loaded it
// from the queue, which is written at the edge that accepts the closing
// bracket. Beats follow at one per cycle while the receiver is ready, so the
// result port sets the sustained rate.
// When the receiver stalls, the output register holds its beat, the emitter
// waits, and the parser keeps taking bytes until the queue is full.
// Reset clears the parser to idle, empties the queue and drops any pending beat.
module bracket_charset_compiler_unit
    import bcc_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    output logic              text_ready,
    input  logic [7:0]        char_code,
    input  logic              end_of_text,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [WIDX_W-1:0] word_index,
    output logic [WORD_W-1:0] set_bits,
    output logic              inverted,
    output logic              parse_error,
    output logic              last
);

    bcc_qstat_t qstat;
    bcc_job_t   push_job;
    bcc_job_t   head;
    logic       push;
    logic       pop;

    // The parser folds each byte into the bitmap and pushes a finished class
    // or an error as one job.
    bcc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .qstat       (qstat),
        .push        (push),
        .job         (push_job)
    );

    // The queue decouples parsing of the next class from emission of this one.
    bcc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    // The emitter slices the head job into beats.
    bcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .word_index   (word_index),
        .set_bits     (set_bits),
        .inverted     (inverted),
        .parse_error  (parse_error),
        .last         (last)
    );

    // An error beat stands alone and carries no bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && parse_error |-> last && set_bits == '0 && word_index == '0)
        else $error("error beat malformed");

    // A good class ends exactly on its top word.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !parse_error |-> last == (word_index == WIDX_W'(NWORDS - 1)))
        else $error("last misplaced in class");

    // Words of one class leave back to back in order.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !last |=>
            result_valid && word_index == $past(word_index) + 1'b1)
        else $error("class words out of order");

    // The parser never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("job queue overflow");

endmodule
